// ----- sv/rtc_snapshot_pair_to_datetime_macros.svh -----
// assertion macros shared by the rtc snapshot pair datetime block
`ifndef RTC_SNAPSHOT_PAIR_TO_DATETIME_MACROS_SVH
`define RTC_SNAPSHOT_PAIR_TO_DATETIME_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RTCSP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define RTCSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rtcsp_pkg.sv -----
// types, constants and the bcd helper for the rtc snapshot pair datetime block
package rtcsp_pkg;

    localparam int unsigned BIN_MODE_BIT = 2;
    localparam int unsigned H24_MODE_BIT = 1;
    localparam int unsigned PM_BIT       = 7;

    localparam logic [7:0]  HOUR_MASK     = 8'h7F;
    localparam logic [7:0]  NOON_HOUR     = 8'd12;
    localparam logic [14:0] YEAR_BASE     = 15'd2000;
    localparam logic [14:0] CENTURY_SCALE = 15'd100;

    // clock bytes, one per field from century down to second, seconds in the low byte
    typedef struct packed {
        logic [7:0] century;
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } snap_t;

    // converted datetime, seconds in the low byte, one pad bit on top
    typedef struct packed {
        logic       pad;
        logic [7:0] century;
        logic [14:0] full_year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } datetime_t;

    // per-transaction decision from the pair tracker
    typedef struct packed {
        logic emit;
        logic fail;
    } pair_ctl_t;

    // low nibble plus ten times the high nibble, no digit check
    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return {4'd0, b[3:0]} + (hi << 3) + (hi << 1);
    endfunction

endpackage

// ----- sv/rtc_snapshot_pair_to_datetime.sv -----
// top level: consistent rtc read from snapshot pairs to a binary datetime
//
//  channel   direction  payload
//  s_axis    in         tdata: raw clock bytes and status b
//  m_axis    out        tdata: converted datetime, tuser: outcome
//
// s_axis takes one transaction per cycle while the result register is free; an
// accepted item is registered in the input register, then in the result register,
// and m_axis gives at most one result per snapshot pair
// the first snapshot of a pair and a mismatched pair below the limit give no
// result; the second of a matching pair, or the pair that hits the limit, gives one
// reset clears the pair phase, the held snapshot, the mismatch counter and
// both valid flags
// a stalled m_axis holds the result register; the input register still fills,
// then s_axis_tready drops until the result is taken
`include "rtc_snapshot_pair_to_datetime_macros.svh"

module rtc_snapshot_pair_to_datetime #(
    parameter int MAX_ATTEMPTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // raw_second, raw_minute, raw_hr, raw_day, raw_month, raw_year,
    // raw_century, status_flags (8 bits each)
    input  logic [63:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // second, minute, hour, day, month (8 each), full_year (15), century (8),
    // one zero pad bit
    output logic [63:0] m_axis_tdata,
    // outcome: 0 consistent datetime, 1 gave up after too many mismatches
    output logic [0:0]  m_axis_tuser
);

    // input register
    logic                 in_valid_reg;
    rtcsp_pkg::snap_t     in_snap_reg;
    logic [7:0]           in_status_reg;

    // result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_fail_reg;
    rtcsp_pkg::datetime_t out_data_reg;

    logic                 out_free;
    logic                 step;
    rtcsp_pkg::pair_ctl_t ctl;
    rtcsp_pkg::datetime_t conv;

    // result register can load when empty or being drained this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_snap_reg   <= rtcsp_pkg::snap_t'(s_axis_tdata[55:0]);
            in_status_reg <= s_axis_tdata[63:56];
        end
    end

    rtcsp_pair_track #(
        .MAX_ATTEMPTS (MAX_ATTEMPTS)
    ) u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .snap  (in_snap_reg),
        .ctl   (ctl)
    );

    rtcsp_convert u_convert (
        .snap   (in_snap_reg),
        .status (in_status_reg),
        .result (conv)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = step && ctl.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // a failure result carries all-zero data
    always_ff @(posedge clk)
    begin
        if (step && ctl.emit)
        begin
            out_fail_reg <= ctl.fail;
            out_data_reg <= ctl.fail ? '0 : conv;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_fail_reg;

    `RTCSP_ASSERT_IMPL(a_fail_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 64'd0, "failure result carries data")
    `RTCSP_ASSERT_NEXT(a_no_invented, !in_valid_reg && !out_valid_reg, !out_valid_reg, "result without an item")
    `RTCSP_ASSERT_IMPL(a_year_range, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[54:40] <= 15'd25755, "full year out of range")
    `RTCSP_ASSERT_IMPL(a_hour_range, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[23:16] <= 8'd139, "hour out of range")

endmodule

// ----- sv/rtcsp_convert.sv -----
// bcd, 12-hour and century conversion of one matched snapshot
module rtcsp_convert (
    input  rtcsp_pkg::snap_t     snap,
    input  logic [7:0]           status,
    output rtcsp_pkg::datetime_t result
);

    rtcsp_pkg::snap_t dec;
    logic             pm;
    logic [7:0]       hr_masked;
    logic [7:0]       hr;

    assign pm        = snap.hour[rtcsp_pkg::PM_BIT];
    assign hr_masked = snap.hour & rtcsp_pkg::HOUR_MASK;

    always_comb
    begin
        dec      = snap;
        dec.hour = hr_masked;
        if (!status[rtcsp_pkg::BIN_MODE_BIT])
        begin
            dec.second  = rtcsp_pkg::bcd_value(snap.second);
            dec.minute  = rtcsp_pkg::bcd_value(snap.minute);
            dec.hour    = rtcsp_pkg::bcd_value(hr_masked);
            dec.day     = rtcsp_pkg::bcd_value(snap.day);
            dec.month   = rtcsp_pkg::bcd_value(snap.month);
            dec.year    = rtcsp_pkg::bcd_value(snap.year);
            dec.century = rtcsp_pkg::bcd_value(snap.century);
        end
    end

    // 12-hour to 24-hour fold
    always_comb
    begin
        hr = dec.hour;
        if (!status[rtcsp_pkg::H24_MODE_BIT])
        begin
            if (pm)
            begin
                if (dec.hour != rtcsp_pkg::NOON_HOUR)
                    hr = dec.hour + rtcsp_pkg::NOON_HOUR;
            end
            else if (dec.hour == rtcsp_pkg::NOON_HOUR)
            begin
                hr = 8'd0;
            end
        end
    end

    always_comb
    begin
        result         = '0;
        result.second  = dec.second;
        result.minute  = dec.minute;
        result.hour    = hr;
        result.day     = dec.day;
        result.month   = dec.month;
        result.century = dec.century;
        if (dec.century != 8'd0)
            result.full_year = {7'd0, dec.century} * rtcsp_pkg::CENTURY_SCALE
                               + {7'd0, dec.year};
        else
            result.full_year = rtcsp_pkg::YEAR_BASE + {7'd0, dec.year};
    end

endmodule

// ----- sv/rtcsp_pair_track.sv -----
// pair phase, held snapshot and mismatch counter
module rtcsp_pair_track #(
    parameter int MAX_ATTEMPTS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  rtcsp_pkg::snap_t     snap,
    output rtcsp_pkg::pair_ctl_t ctl
);

    localparam int CNT_W = $clog2(MAX_ATTEMPTS + 1);

    rtcsp_pkg::snap_t held_reg;
    logic             phase_reg;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_next;
    logic [CNT_W-1:0] miss_cnt_inc;
    logic             match;
    logic             at_limit;

    assign match        = (held_reg == snap);
    assign miss_cnt_inc = miss_cnt_reg + 1'b1;
    assign at_limit     = (miss_cnt_inc >= CNT_W'(MAX_ATTEMPTS));

    assign ctl.fail = phase_reg && !match && at_limit;
    assign ctl.emit = phase_reg && (match || at_limit);

    always_comb
    begin
        miss_cnt_next = miss_cnt_reg;
        if (phase_reg)
        begin
            if (match || at_limit)
                miss_cnt_next = '0;
            else
                miss_cnt_next = miss_cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            phase_reg    <= 1'b0;
            miss_cnt_reg <= '0;
        end
        else if (step)
        begin
            if (!phase_reg)
                held_reg <= snap;
            phase_reg    <= !phase_reg;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// testbench for rtc_snapshot_pair_to_datetime: directed and random snapshot pairs checked against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // outcome codes carried on m_axis_tuser
    localparam logic OUTCOME_OK      = 1'b0;
    localparam logic OUTCOME_GAVE_UP = 1'b1;

    // mismatched pairs before the block gives up
    localparam int ATTEMPT_LIMIT = 8;

    // status b values used by the directed cases
    localparam logic [7:0] STATUS_BCD_12H = 8'h00;
    localparam logic [7:0] STATUS_24H     = 8'h02;
    localparam logic [7:0] STATUS_BINARY  = 8'h04;
    localparam logic [7:0] STATUS_ALL_SET = 8'hFF;

    localparam int REPORT_LIMIT = 10;

    // one expected output transaction
    typedef struct packed {
        logic                 outcome;
        rtcsp_pkg::datetime_t stamp;
    } datetime_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // raw_second, raw_minute, raw_hr, raw_day, raw_month, raw_year,
    // raw_century, status_flags (8 bits each)
    logic [63:0] s_axis_tdata = '0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // second, minute, hour, day, month (8 each), full_year (15), century (8), pad
    logic [63:0] m_axis_tdata;
    // outcome
    logic [0:0]  m_axis_tuser;

    // predictor state: held first snapshot, pair phase, run of mismatched pairs
    rtcsp_pkg::snap_t held_clock = '0;
    logic             awaiting_second = 1'b0;
    int               mismatch_run = 0;

    // datetimes still owed by the block, oldest first
    datetime_result_t expected_datetimes[$];

    int error_count = 0;
    int snapshots_sent = 0;

    // idling controls, in percent of cycles
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off, handed to the receiver process in cycles
    int hold_request = 0;
    int hold_left = 0;

    rtc_snapshot_pair_to_datetime #(
        .MAX_ATTEMPTS (ATTEMPT_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

    // counts a failure, details only for the first few
    function automatic void log_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            log_failure($sformatf("%s expected %0d got %0d", name, want, got));
        end
    endfunction

    // two bcd digits as binary, bad digits taken at face value
    function automatic logic [7:0] bcd_to_binary(input logic [7:0] b);
        int v;
        v = int'(b[7:4]) * 10 + int'(b[3:0]);
        return v[7:0];
    endfunction

    // binary 0..99 as two bcd digits
    function automatic logic [7:0] binary_to_bcd(input int v);
        logic [3:0] tens;
        logic [3:0] ones;
        tens = 4'(v / 10);
        ones = 4'(v % 10);
        return {tens, ones};
    endfunction

    // predictor: runs once per accepted input transaction
    function automatic void predict_snapshot(input rtcsp_pkg::snap_t clock,
                                             input logic [7:0] status);
        datetime_result_t r;
        logic             pm;
        logic [7:0]       yr;
        int               full;
        r = '0;
        // first of a pair is only held
        if (!awaiting_second)
        begin
            held_clock = clock;
            awaiting_second = 1'b1;
            return;
        end
        awaiting_second = 1'b0;

        // torn read: drop the pair, give up once the limit is reached
        if (clock != held_clock)
        begin
            mismatch_run++;
            if (mismatch_run >= ATTEMPT_LIMIT)
            begin
                mismatch_run = 0;
                r.outcome = OUTCOME_GAVE_UP;
                expected_datetimes.push_back(r);
            end
            return;
        end
        mismatch_run = 0;

        pm = clock.hour[rtcsp_pkg::PM_BIT];
        r.outcome = OUTCOME_OK;
        r.stamp.second = clock.second;
        r.stamp.minute = clock.minute;
        r.stamp.hour = clock.hour & 8'h7F;
        r.stamp.day = clock.day;
        r.stamp.month = clock.month;
        r.stamp.century = clock.century;
        yr = clock.year;

        // status b from the second snapshot decides the encoding
        if (!status[rtcsp_pkg::BIN_MODE_BIT])
        begin
            r.stamp.second = bcd_to_binary(r.stamp.second);
            r.stamp.minute = bcd_to_binary(r.stamp.minute);
            r.stamp.hour = bcd_to_binary(r.stamp.hour);
            r.stamp.day = bcd_to_binary(r.stamp.day);
            r.stamp.month = bcd_to_binary(r.stamp.month);
            r.stamp.century = bcd_to_binary(r.stamp.century);
            yr = bcd_to_binary(yr);
        end

        // 12-hour to 24-hour, no range check on the hour
        if (!status[rtcsp_pkg::H24_MODE_BIT])
        begin
            if (pm)
            begin
                if (r.stamp.hour != 8'd12)
                begin
                    r.stamp.hour = r.stamp.hour + 8'd12;
                end
            end
            else if (r.stamp.hour == 8'd12)
            begin
                r.stamp.hour = 8'd0;
            end
        end

        // no century register means the 2000s
        if (r.stamp.century != 8'd0)
        begin
            full = int'(r.stamp.century) * 100 + int'(yr);
        end
        else
        begin
            full = 2000 + int'(yr);
        end
        r.stamp.full_year = full[14:0];
        expected_datetimes.push_back(r);
    endfunction

    // random clock: half arbitrary bytes, half plausible bcd times
    function automatic rtcsp_pkg::snap_t random_clock();
        rtcsp_pkg::snap_t c;
        logic [1:0]       cen_pick;
        if ($urandom_range(1) == 1)
        begin
            c[31:0] = $urandom();
            c[55:32] = 24'($urandom());
        end
        else
        begin
            c.second = binary_to_bcd($urandom_range(59));
            c.minute = binary_to_bcd($urandom_range(59));
            c.hour = {1'($urandom_range(1)), 7'(binary_to_bcd($urandom_range(12, 1)))};
            c.day = binary_to_bcd($urandom_range(31, 1));
            c.month = binary_to_bcd($urandom_range(12, 1));
            c.year = binary_to_bcd($urandom_range(99));
            cen_pick = 2'($urandom_range(3));
            c.century = (cen_pick == 2'd0) ? 8'h00 : (cen_pick == 2'd1) ? 8'h19 :
                        (cen_pick == 2'd2) ? 8'h20 : 8'h21;
        end
        return c;
    endfunction

    // second read that tore: one bit off, or a different clock altogether
    function automatic rtcsp_pkg::snap_t disturb_clock(input rtcsp_pkg::snap_t c);
        rtcsp_pkg::snap_t d;
        if ($urandom_range(3) == 0)
        begin
            d = random_clock();
        end
        else
        begin
            d = c ^ (56'h1 << $urandom_range(55));
        end
        return d;
    endfunction

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // checker: every output transaction against the oldest expectation
    always @(posedge clk)
    begin : result_check
        datetime_result_t     want;
        rtcsp_pkg::datetime_t got;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_datetimes.size() == 0)
            begin
                log_failure($sformatf("result with none expected: tuser %0d tdata %h",
                                      m_axis_tuser, m_axis_tdata));
            end
            else
            begin
                want = expected_datetimes.pop_front();
                check_field("outcome", 16'(want.outcome), 16'(m_axis_tuser[0]));
                check_field("second", 16'(want.stamp.second), 16'(got.second));
                check_field("minute", 16'(want.stamp.minute), 16'(got.minute));
                check_field("hour", 16'(want.stamp.hour), 16'(got.hour));
                check_field("day", 16'(want.stamp.day), 16'(got.day));
                check_field("month", 16'(want.stamp.month), 16'(got.month));
                check_field("full_year", 16'(want.stamp.full_year), 16'(got.full_year));
                check_field("century", 16'(want.stamp.century), 16'(got.century));
                check_field("pad", 16'(1'b0), 16'(got.pad));
            end
        end
    end

    // one input transaction: optional idle gap, then hold tvalid until taken
    task automatic send_snapshot(input rtcsp_pkg::snap_t clock, input logic [7:0] status);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {status, clock};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predict_snapshot(clock, status);
        snapshots_sent++;
    endtask

    // sender pauses until every owed datetime has come out
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_datetimes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic rtcsp_pkg::snap_t clock_of(input logic [7:0] sec,
                                                  input logic [7:0] mnt,
                                                  input logic [7:0] hr,
                                                  input logic [7:0] dy,
                                                  input logic [7:0] mon,
                                                  input logic [7:0] yr,
                                                  input logic [7:0] cen);
        return {cen, yr, mon, dy, hr, mnt, sec};
    endfunction

    // field extremes, both encodings, both hour modes, noon and midnight
    task automatic test_conversion_corners();
        rtcsp_pkg::snap_t c;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // all zero, status of the first item must be ignored
        c = '0;
        send_snapshot(c, STATUS_ALL_SET);
        send_snapshot(c, STATUS_BCD_12H);
        // all ones as bcd with pm set: bad digits and an out-of-range hour
        c = '1;
        send_snapshot(c, STATUS_BCD_12H);
        send_snapshot(c, STATUS_BCD_12H);
        // all ones in binary 24-hour mode: largest year
        send_snapshot(c, STATUS_ALL_SET);
        send_snapshot(c, STATUS_ALL_SET);
        // 12 pm stays 12
        c = clock_of(8'h59, 8'h59, 8'h92, 8'h31, 8'h12, 8'h99, 8'h20);
        send_snapshot(c, STATUS_BCD_12H);
        send_snapshot(c, STATUS_BCD_12H);
        // 12 am becomes 0, no century
        c = clock_of(8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h00, 8'h00);
        send_snapshot(c, STATUS_BCD_12H);
        send_snapshot(c, STATUS_BCD_12H);
        // 24-hour bcd passes the hour through
        c = clock_of(8'h30, 8'h15, 8'h23, 8'h28, 8'h02, 8'h24, 8'h21);
        send_snapshot(c, STATUS_24H);
        send_snapshot(c, STATUS_24H);
        // binary 12-hour: 11 pm
        c = clock_of(8'd59, 8'd0, 8'h8B, 8'd15, 8'd7, 8'd99, 8'd19);
        send_snapshot(c, STATUS_BINARY);
        send_snapshot(c, STATUS_BINARY);
        wait_for_results();
    endtask

    // eight torn pairs in a row give the failure result
    task automatic test_mismatch_limit();
        rtcsp_pkg::snap_t c;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < ATTEMPT_LIMIT; i++)
        begin
            c = random_clock();
            send_snapshot(c, STATUS_BCD_12H);
            send_snapshot(c ^ (56'h1 << (8 * (i % 7) + i)), STATUS_BCD_12H);
        end
        wait_for_results();
    endtask

    // receiver holds off while the sender keeps offering, so s_axis stalls
    task automatic test_backpressure();
        rtcsp_pkg::snap_t c;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 60;
        for (int i = 0; i < 12; i++)
        begin
            c = random_clock();
            send_snapshot(c, 8'($urandom_range(255)));
            send_snapshot(c, 8'($urandom_range(255)));
        end
        wait_for_results();
    endtask

    // mostly matching pairs, torn pairs, bursts of torn pairs and lone items
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        int               target;
        int               pick;
        int               burst;
        rtcsp_pkg::snap_t c;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        target = snapshots_sent + count;
        while (snapshots_sent < target)
        begin
            pick = $urandom_range(99);
            c = random_clock();
            // realign to the start of a pair after a lone item
            if (awaiting_second && pick < 92)
            begin
                send_snapshot(random_clock(), 8'($urandom_range(255)));
            end
            if (pick < 55)
            begin
                send_snapshot(c, 8'($urandom_range(255)));
                send_snapshot(c, 8'($urandom_range(255)));
            end
            else if (pick < 80)
            begin
                send_snapshot(c, 8'($urandom_range(255)));
                send_snapshot(disturb_clock(c), 8'($urandom_range(255)));
            end
            else if (pick < 92)
            begin
                burst = $urandom_range(9, 7);
                repeat (burst)
                begin
                    c = random_clock();
                    send_snapshot(c, 8'($urandom_range(255)));
                    send_snapshot(disturb_clock(c), 8'($urandom_range(255)));
                end
            end
            else
            begin
                send_snapshot(c, 8'($urandom_range(255)));
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        // reset once, released on a clock edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_conversion_corners();
        test_mismatch_limit();
        test_backpressure();
        test_random_traffic(180, 0, 0);
        test_random_traffic(180, 63, 0);
        test_random_traffic(180, 0, 63);
        test_random_traffic(180, 28, 28);

        // let the two-stage pipe settle, catch stray results
        repeat (8) @(posedge clk);
        if (expected_datetimes.size() != 0)
        begin
            log_failure($sformatf("%0d results never arrived", expected_datetimes.size()));
        end

        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/rtcsp_pkg.sv
sv/rtcsp_convert.sv
sv/rtcsp_pair_track.sv
sv/rtc_snapshot_pair_to_datetime.sv
tb/tb_top.sv
